// ----- src/fmtg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmtg_pkg: FM tone generator shared definitions
// Widths, register indexes, FSM states and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package fmtg_pkg;

  localparam int PHASE_BITS     = 32;
  localparam int SINE_ADDR_BITS = 10;
  localparam int COUNT_BITS     = 24;

  // register widths
  localparam int AMP_W     = 16;
  localparam int STEP_W    = 32;
  localparam int MODIDX_W  = 40;
  localparam int SCOUNT_W  = 24;
  localparam int SAMPLE_W  = 16;

  localparam int CFG_DATA_W = 40;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CARRIER_STEP = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MOD_STEP     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_MOD_INDEX    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = CFG_IDX_W'(4);

  localparam logic [AMP_W-1:0]    AMP_RESET      = AMP_W'(32768);
  localparam logic [STEP_W-1:0]   MOD_STEP_RESET = STEP_W'(1);

  // sine magnitude and fixed-point scaling
  localparam int MAG_W     = 15;
  localparam int FRAC_BITS = 15;
  localparam logic [MAG_W-1:0] SINE_FULL = MAG_W'(32767);
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // radix-4 shift-add multiplier
  localparam int MUL_B_W     = MAG_W + 1;
  localparam int MUL_DIGITS  = MUL_B_W / 2;
  localparam int MUL_CNT_W   = $clog2(MUL_DIGITS);
  localparam int PROD_W      = MODIDX_W + MUL_B_W;

  localparam int QUARTER_LEN = 1 << (SINE_ADDR_BITS - 2);
  localparam int QIDX_W      = SINE_ADDR_BITS - 1;

  typedef logic [MAG_W-1:0] quarter_tab_t [QUARTER_LEN+1];

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } sine_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKM,
    ST_MULM,
    ST_OFFS,
    ST_PHASE,
    ST_LOOKC,
    ST_MULC,
    ST_DONE
  } state_t;

  // Quarter wave in Q30 by Taylor series up to x^15, then scaled to 32767.
  function automatic quarter_tab_t build_quarter_tab();
    quarter_tab_t       tab;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic signed [63:0] s;
    logic [63:0]        v;
    for (int q = 0; q <= QUARTER_LEN; q++) begin
      x  = (64'(q) * HALF_PI_Q30 + 64'(QUARTER_LEN / 2)) / 64'(QUARTER_LEN);
      x2 = (x * x) >> 30;
      t  = x;
      s  = $signed(x);
      t  = ((t * x2) >> 30) / 64'd6;
      s  = s - $signed(t);
      t  = ((t * x2) >> 30) / 64'd20;
      s  = s + $signed(t);
      t  = ((t * x2) >> 30) / 64'd42;
      s  = s - $signed(t);
      t  = ((t * x2) >> 30) / 64'd72;
      s  = s + $signed(t);
      t  = ((t * x2) >> 30) / 64'd110;
      s  = s - $signed(t);
      t  = ((t * x2) >> 30) / 64'd156;
      s  = s + $signed(t);
      t  = ((t * x2) >> 30) / 64'd210;
      s  = s - $signed(t);
      if (s < 0) s = 0;
      if (s > (64'sd1 <<< 30)) s = 64'sd1 <<< 30;
      v = ($unsigned(s) * 64'(SINE_FULL) + (64'd1 << 29)) >> 30;
      if (v > 64'(SINE_FULL)) v = 64'(SINE_FULL);
      tab[q] = v[MAG_W-1:0];
    end
    return tab;
  endfunction

  localparam quarter_tab_t QUARTER_TAB = build_quarter_tab();

  // Full-wave lookup by quadrant symmetry; address is the top phase bits.
  function automatic sine_t sine_lookup(input logic [SINE_ADDR_BITS-1:0] addr);
    sine_t            res;
    logic [1:0]       quad;
    logic [QIDX_W-1:0] r;
    logic [QIDX_W-1:0] idx;
    quad = addr[SINE_ADDR_BITS-1 -: 2];
    r    = {1'b0, addr[SINE_ADDR_BITS-3:0]};
    idx  = quad[0] ? (QIDX_W'(QUARTER_LEN) - r) : r;
    res.neg = quad[1];
    res.mag = QUARTER_TAB[idx];
    return res;
  endfunction

endpackage

// ----- src/fmtg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmtg_if: FM tone generator channels
// Tick channel (restart flag) and sample channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fmtg_tick_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface fmtg_sample_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  sample;
  logic                last;
  logic                active;

  modport source (output valid, output sample, output last, output active, input ready);
  modport sink (input valid, input sample, input last, input active, output ready);
endinterface

// ----- src/fm_tone_generator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fm_tone_generator_unit: two-operator FM tone generator
// Each tick transfer yields one signed 16-bit sample from a modulator and a
// carrier phase accumulator, both looked up in the quarter-wave sine table.
// ----------------------------------------------------------------------------
// Usage:
//   tick   : one transfer per sample; restart=1 zeroes both phases and the
//            sample index before that sample is made.
//   result : sample, last, active, held in an output register until taken.
//   cfg_*  : write enable, register index and data; write only while idle.
// Sequence: a sample inside the tone passes LOOKM, MULM, OFFS, PHASE, LOOKC,
//   MULC and DONE; the next tick is taken once DONE hands the result on.
//   Two products (mod_index * sine, amplitude * sine) run through one
//   radix-4 shift-add multiplier, one after the other. Past the end of the
//   tone a zero sample goes straight from IDLE to DONE.
// Reset: registers go to their defaults, phases and sample index to zero,
//   the output register empties.
// Stall: while a result waits, the next tick is taken and computed; the
//   block then holds its new result until the output register frees up.
// ----------------------------------------------------------------------------
module fm_tone_generator_unit
  import fmtg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  fmtg_tick_if.sink             tick,
  fmtg_sample_if.source         result
);

  // configuration
  logic [AMP_W-1:0]    amplitude;
  logic [STEP_W-1:0]   carrier_step;
  logic [STEP_W-1:0]   mod_step;
  logic [MODIDX_W-1:0] mod_index;
  logic [SCOUNT_W-1:0] sample_count;

  // oscillator state
  logic [PHASE_BITS-1:0] carrier_phase;
  logic [PHASE_BITS-1:0] mod_phase;
  logic [COUNT_BITS-1:0] sample_index;

  state_t state, state_next;

  // datapath
  logic                  act;
  logic                  last_flag;
  logic                  mneg;
  logic                  cneg;
  logic [PHASE_BITS-1:0] phase_work;
  logic [MODIDX_W-1:0]   mul_a;
  logic [MODIDX_W-1:0]   mul_hi;
  logic [MUL_B_W-1:0]    mul_lo;
  logic [MUL_CNT_W-1:0]  mcnt;

  // output register
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_last;
  logic                       out_active;

  logic accept;
  logic out_load;
  logic mul_last;

  logic [COUNT_BITS-1:0]   count;
  logic [COUNT_BITS-1:0]   idx_eff;
  logic                    active_now;
  logic                    last_now;
  sine_t                   msin;
  sine_t                   csin;
  logic [MODIDX_W+1:0]     pp;
  logic [MODIDX_W+1:0]     mul_sum;
  logic [PROD_W-1:0]       prod;
  logic [PROD_W-FRAC_BITS:0] off_sum;
  logic [MAG_W+1:0]        rnd;
  logic [MAG_W-1:0]        mag;
  logic signed [SAMPLE_W-1:0] sample_val;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude    <= AMP_RESET;
      carrier_step <= '0;
      mod_step     <= MOD_STEP_RESET;
      mod_index    <= '0;
      sample_count <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_AMPLITUDE:    amplitude    <= cfg_data[AMP_W-1:0];
        REG_CARRIER_STEP: carrier_step <= cfg_data[STEP_W-1:0];
        REG_MOD_STEP:     mod_step     <= cfg_data[STEP_W-1:0];
        REG_MOD_INDEX:    mod_index    <= cfg_data[MODIDX_W-1:0];
        REG_SAMPLE_COUNT: sample_count <= cfg_data[SCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- combinational datapath
  assign count      = COUNT_BITS'(sample_count);
  assign idx_eff    = tick.restart ? '0 : sample_index;
  assign active_now = idx_eff < count;
  assign last_now   = ({1'b0, idx_eff} + (COUNT_BITS+1)'(1)) == {1'b0, count};

  assign msin = sine_lookup(mod_phase[PHASE_BITS-1 -: SINE_ADDR_BITS]);
  assign csin = sine_lookup(phase_work[PHASE_BITS-1 -: SINE_ADDR_BITS]);

  // one radix-4 step: two multiplier bits per cycle, LSB first
  assign pp = (mul_lo[0] ? {2'b00, mul_a} : '0) + (mul_lo[1] ? {1'b0, mul_a, 1'b0} : '0);
  assign mul_sum  = {2'b00, mul_hi} + pp;
  assign mul_last = mcnt == MUL_CNT_W'(MUL_DIGITS - 1);
  assign prod     = {mul_hi, mul_lo};

  // round half away from zero on the magnitude
  assign off_sum = {1'b0, prod[PROD_W-1:FRAC_BITS]}
                   + (PROD_W-FRAC_BITS+1)'(prod[FRAC_BITS-1]);
  assign rnd     = {1'b0, prod[FRAC_BITS+MAG_W:FRAC_BITS]}
                   + (MAG_W+2)'(prod[FRAC_BITS-1]);
  assign mag     = (rnd > (MAG_W+2)'(SINE_FULL)) ? SINE_FULL : rnd[MAG_W-1:0];
  assign sample_val = cneg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  // ---------------------------------------------------------------- FSM
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) state_next = active_now ? ST_LOOKM : ST_DONE;
      ST_LOOKM: state_next = ST_MULM;
      ST_MULM:  if (mul_last) state_next = ST_OFFS;
      ST_OFFS:  state_next = ST_PHASE;
      ST_PHASE: state_next = ST_LOOKC;
      ST_LOOKC: state_next = ST_MULC;
      ST_MULC:  if (mul_last) state_next = ST_DONE;
      ST_DONE:  if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    tick.ready = state == ST_IDLE;
    accept     = tick.valid && (state == ST_IDLE);
    out_load   = (state == ST_DONE) && (!out_valid || result.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------- oscillator state
  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_phase <= '0;
      mod_phase     <= '0;
      sample_index  <= '0;
    end else if (accept && tick.restart) begin
      carrier_phase <= '0;
      mod_phase     <= '0;
      sample_index  <= '0;
    end else if (state == ST_LOOKC) begin
      // both phases were consumed by now; advance for the next sample
      carrier_phase <= carrier_phase + PHASE_BITS'(carrier_step);
      mod_phase     <= mod_phase + PHASE_BITS'(mod_step);
      sample_index  <= sample_index + COUNT_BITS'(1);
    end
  end

  // ---------------------------------------------------------------- datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          act       <= active_now;
          last_flag <= last_now;
        end
      end
      ST_LOOKM: begin
        mneg   <= msin.neg;
        mul_a  <= mod_index;
        mul_hi <= '0;
        mul_lo <= {1'b0, msin.mag};
        mcnt   <= '0;
      end
      ST_MULM, ST_MULC: begin
        mul_hi <= mul_sum[MODIDX_W+1:2];
        mul_lo <= {mul_sum[1:0], mul_lo[MUL_B_W-1:2]};
        mcnt   <= mcnt + MUL_CNT_W'(1);
      end
      ST_OFFS: begin
        phase_work <= PHASE_BITS'(off_sum);
      end
      ST_PHASE: begin
        phase_work <= mneg ? (carrier_phase - phase_work) : (carrier_phase + phase_work);
      end
      ST_LOOKC: begin
        cneg   <= csin.neg;
        mul_a  <= MODIDX_W'(amplitude);
        mul_hi <= '0;
        mul_lo <= {1'b0, csin.mag};
        mcnt   <= '0;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample <= act ? sample_val : '0;
      out_last   <= act && last_flag;
      out_active <= act;
    end
  end

  assign result.valid  = out_valid;
  assign result.sample = out_sample;
  assign result.last   = out_last;
  assign result.active = out_active;

`ifndef ASSERT_OFF
  // outside the tone the sample is silent and never flagged last
  a_inactive_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_active |-> out_sample == '0 && !out_last)
    else $error("inactive sample not zero");

  // saturation keeps the sample symmetric
  a_no_min_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_sample != $signed({1'b1, {(SAMPLE_W-1){1'b0}}}))
    else $error("sample reached the negative full-scale code");

  // each computed sample advances the index by exactly one
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOOKC |=> sample_index == $past(sample_index) + COUNT_BITS'(1))
    else $error("sample index did not advance");

  // a finished sample waits in DONE only while the output register is held
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && out_valid && !result.ready |=> state == ST_DONE)
    else $error("result overwritten while output stalled");
`endif

endmodule
